// ----- src/jpd_pkg.sv -----
// jpd_pkg: shared types, constants, microcode and saturation helpers for the
// jacobi polynomial evaluator. No dependencies; used by every module of the block but jpd_ram and the checker.
`timescale 1ns / 1ps
`default_nettype none

package jpd_pkg;

    localparam int DATA_W    = 64;
    localparam int CFG_W     = 32;
    localparam int DEG_W     = 6;
    localparam int PC_W      = 6;
    localparam int OPND_W    = 6;
    localparam int RF_AW     = 5;
    localparam int RF_DEPTH  = 32;
    localparam int DIV_SH    = 24;
    localparam int DVD_W     = DATA_W + DIV_SH;

    localparam logic [DEG_W-1:0] MAX_DEGREE_LIMIT = 6'd63;

    // configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_ALPHA  = 2'd0;
    localparam logic [1:0] REG_BETA   = 2'd1;
    localparam logic [1:0] REG_DEGREE = 2'd2;

    localparam logic [DATA_W-1:0] ONE_Q24 = 64'd16777216;
    localparam logic [DATA_W-1:0] TWO_Q24 = 64'd33554432;
    localparam logic [DATA_W-1:0] ONE_Q40 = 64'h0000_0100_0000_0000;
    localparam logic [DATA_W-1:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] LIM_NEG = 64'h8000_0000_0000_0000;

    // register file slots
    localparam logic [OPND_W-1:0] R_S   = 6'd0;
    localparam logic [OPND_W-1:0] R_H   = 6'd1;
    localparam logic [OPND_W-1:0] R_KQ  = 6'd2;
    localparam logic [OPND_W-1:0] R_T0  = 6'd3;
    localparam logic [OPND_W-1:0] R_T1  = 6'd4;
    localparam logic [OPND_W-1:0] R_T2  = 6'd5;
    localparam logic [OPND_W-1:0] R_U   = 6'd6;
    localparam logic [OPND_W-1:0] R_DD  = 6'd7;
    localparam logic [OPND_W-1:0] R_AA  = 6'd8;
    localparam logic [OPND_W-1:0] R_BB  = 6'd9;
    localparam logic [OPND_W-1:0] R_CC  = 6'd10;
    localparam logic [OPND_W-1:0] R_LIN = 6'd11;
    localparam logic [OPND_W-1:0] R_J0  = 6'd12;
    localparam logic [OPND_W-1:0] R_J1  = 6'd13;
    localparam logic [OPND_W-1:0] R_D0  = 6'd14;
    localparam logic [OPND_W-1:0] R_D1  = 6'd15;
    localparam logic [OPND_W-1:0] R_P1  = 6'd16;
    localparam logic [OPND_W-1:0] R_P2  = 6'd17;
    localparam logic [OPND_W-1:0] R_P3  = 6'd18;

    // fixed operands (msb set)
    localparam logic [OPND_W-1:0] K_ZERO  = 6'd32;
    localparam logic [OPND_W-1:0] K_ONE   = 6'd33;
    localparam logic [OPND_W-1:0] K_TWO   = 6'd34;
    localparam logic [OPND_W-1:0] K_X     = 6'd35;
    localparam logic [OPND_W-1:0] K_ALPHA = 6'd36;
    localparam logic [OPND_W-1:0] K_BETA  = 6'd37;
    localparam logic [OPND_W-1:0] K_C40   = 6'd38;

    localparam logic [PC_W-1:0] LOOP_PC = 6'd12;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MOV  = 3'd2,
        OP_SHL  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5,
        OP_EMIT = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        SH_15 = 2'd0,
        SH_24 = 2'd1,
        SH_30 = 2'd2
    } sh_t;

    typedef struct packed {
        op_t               op;
        sh_t               sh;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        logic [RF_AW-1:0]  dst;
        logic              br;
    } uop_t;

    typedef struct packed {
        logic              load_x;
        logic              start;
        uop_t              uop;
        logic [DEG_W-1:0]  degree;
        logic              last;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_stat_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } sat_t;

    function automatic logic [DATA_W-1:0] mag64(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (64'd0 - v) : v;
    endfunction

    // clamp a sign and 128-bit magnitude into a signed 64-bit value
    function automatic sat_t sat_pack(input logic neg, input logic [127:0] m);
        sat_t              r;
        logic [DATA_W-1:0] lim;
        logic [DATA_W-1:0] lo;
        lim   = neg ? LIM_NEG : LIM_POS;
        lo    = m[63:0];
        r.ovf = 1'b0;
        if ((m[127:64] != 64'd0) || (lo > lim)) begin
            lo    = lim;
            r.ovf = 1'b1;
        end
        r.val = neg ? (64'd0 - lo) : lo;
        return r;
    endfunction

    function automatic uop_t mk_uop(input op_t op, input logic [OPND_W-1:0] dst,
                                    input logic [OPND_W-1:0] a,
                                    input logic [OPND_W-1:0] b,
                                    input sh_t sh, input logic br);
        uop_t u;
        u.op  = op;
        u.sh  = sh;
        u.a   = a;
        u.b   = b;
        u.dst = dst[RF_AW-1:0];
        u.br  = br;
        return u;
    endfunction

    // microcode: prologue for degrees 0 and 1, then one recurrence step per pass
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        case (pc)
            6'd0:  return mk_uop(OP_ADD,  R_S,   K_ALPHA, K_BETA,  SH_24, 1'b0);
            6'd1:  return mk_uop(OP_ADD,  R_H,   R_S,     K_TWO,   SH_24, 1'b0);
            6'd2:  return mk_uop(OP_MOV,  R_J0,  K_C40,   K_ZERO,  SH_24, 1'b0);
            6'd3:  return mk_uop(OP_MOV,  R_D0,  K_ZERO,  K_ZERO,  SH_24, 1'b0);
            6'd4:  return mk_uop(OP_EMIT, R_P1,  R_J0,    R_D0,    SH_24, 1'b0);
            6'd5:  return mk_uop(OP_MUL,  R_P1,  R_H,     K_X,     SH_15, 1'b0);
            6'd6:  return mk_uop(OP_SUB,  R_P2,  K_ALPHA, K_BETA,  SH_24, 1'b0);
            6'd7:  return mk_uop(OP_SHL,  R_P2,  R_P2,    K_ZERO,  SH_24, 1'b0);
            6'd8:  return mk_uop(OP_ADD,  R_J1,  R_P1,    R_P2,    SH_24, 1'b0);
            6'd9:  return mk_uop(OP_SHL,  R_D1,  R_H,     K_ZERO,  SH_24, 1'b0);
            6'd10: return mk_uop(OP_MOV,  R_KQ,  K_ONE,   K_ZERO,  SH_24, 1'b0);
            6'd11: return mk_uop(OP_EMIT, R_P1,  R_J1,    R_D1,    SH_24, 1'b0);
            6'd12: return mk_uop(OP_ADD,  R_T0,  R_KQ,    R_KQ,    SH_24, 1'b0);
            6'd13: return mk_uop(OP_ADD,  R_T0,  R_T0,    R_S,     SH_24, 1'b0);
            6'd14: return mk_uop(OP_ADD,  R_T1,  R_T0,    K_ONE,   SH_24, 1'b0);
            6'd15: return mk_uop(OP_ADD,  R_T2,  R_T0,    K_TWO,   SH_24, 1'b0);
            6'd16: return mk_uop(OP_ADD,  R_U,   R_KQ,    R_S,     SH_24, 1'b0);
            6'd17: return mk_uop(OP_ADD,  R_U,   R_U,     K_ONE,   SH_24, 1'b0);
            6'd18: return mk_uop(OP_ADD,  R_P1,  R_KQ,    K_ONE,   SH_24, 1'b0);
            6'd19: return mk_uop(OP_ADD,  R_P1,  R_P1,    R_P1,    SH_24, 1'b0);
            6'd20: return mk_uop(OP_MUL,  R_P1,  R_P1,    R_U,     SH_24, 1'b0);
            6'd21: return mk_uop(OP_MUL,  R_DD,  R_P1,    R_T0,    SH_24, 1'b0);
            6'd22: return mk_uop(OP_MUL,  R_P1,  R_T0,    R_T1,    SH_24, 1'b0);
            6'd23: return mk_uop(OP_MUL,  R_AA,  R_P1,    R_T2,    SH_24, 1'b0);
            6'd24: return mk_uop(OP_SUB,  R_P2,  K_BETA,  K_ALPHA, SH_24, 1'b0);
            6'd25: return mk_uop(OP_MUL,  R_P1,  R_S,     R_P2,    SH_24, 1'b0);
            6'd26: return mk_uop(OP_MUL,  R_BB,  R_P1,    R_T1,    SH_24, 1'b0);
            6'd27: return mk_uop(OP_ADD,  R_P1,  R_KQ,    K_ALPHA, SH_24, 1'b0);
            6'd28: return mk_uop(OP_ADD,  R_P1,  R_P1,    R_P1,    SH_24, 1'b0);
            6'd29: return mk_uop(OP_ADD,  R_P2,  R_KQ,    K_BETA,  SH_24, 1'b0);
            6'd30: return mk_uop(OP_MUL,  R_P1,  R_P1,    R_P2,    SH_24, 1'b0);
            6'd31: return mk_uop(OP_MUL,  R_CC,  R_P1,    R_T2,    SH_24, 1'b0);
            6'd32: return mk_uop(OP_MUL,  R_P1,  R_AA,    K_X,     SH_30, 1'b0);
            6'd33: return mk_uop(OP_SUB,  R_LIN, R_P1,    R_BB,    SH_24, 1'b0);
            6'd34: return mk_uop(OP_MUL,  R_P1,  R_LIN,   R_J1,    SH_24, 1'b0);
            6'd35: return mk_uop(OP_MUL,  R_P2,  R_CC,    R_J0,    SH_24, 1'b0);
            6'd36: return mk_uop(OP_SUB,  R_P1,  R_P1,    R_P2,    SH_24, 1'b0);
            6'd37: return mk_uop(OP_DIV,  R_P3,  R_P1,    R_DD,    SH_24, 1'b0);
            6'd38: return mk_uop(OP_MUL,  R_P1,  R_LIN,   R_D1,    SH_24, 1'b0);
            6'd39: return mk_uop(OP_MUL,  R_P2,  R_CC,    R_D0,    SH_24, 1'b0);
            6'd40: return mk_uop(OP_SUB,  R_P1,  R_P1,    R_P2,    SH_24, 1'b0);
            6'd41: return mk_uop(OP_MUL,  R_P2,  R_AA,    R_J1,    SH_24, 1'b0);
            6'd42: return mk_uop(OP_ADD,  R_P1,  R_P1,    R_P2,    SH_24, 1'b0);
            6'd43: return mk_uop(OP_DIV,  R_P2,  R_P1,    R_DD,    SH_24, 1'b0);
            6'd44: return mk_uop(OP_MOV,  R_J0,  R_J1,    K_ZERO,  SH_24, 1'b0);
            6'd45: return mk_uop(OP_MOV,  R_J1,  R_P3,    K_ZERO,  SH_24, 1'b0);
            6'd46: return mk_uop(OP_MOV,  R_D0,  R_D1,    K_ZERO,  SH_24, 1'b0);
            6'd47: return mk_uop(OP_MOV,  R_D1,  R_P2,    K_ZERO,  SH_24, 1'b0);
            6'd48: return mk_uop(OP_ADD,  R_KQ,  R_KQ,    K_ONE,   SH_24, 1'b0);
            6'd49: return mk_uop(OP_EMIT, R_P1,  R_J1,    R_D1,    SH_24, 1'b1);
            default: return mk_uop(OP_MOV, R_P1, K_ZERO,  K_ZERO,  SH_24, 1'b0);
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- src/jpd_ram.sv -----
// jpd_ram: generic single-write, dual-read ram with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module jpd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

`default_nettype wire

// ----- src/jpd_mul.sv -----
// jpd_mul: multi-cycle rounded fixed-point multiplier, 32x32 partial products.
// Depends on jpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jpd_mul
    import jpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] a,
    input  wire logic [DATA_W-1:0] b,
    input  wire sh_t               sh,
    output logic      [DATA_W-1:0] res,
    output logic                   ovf,
    output logic                   done
);

    typedef enum logic [3:0] {
        M_IDLE  = 4'b0001,
        M_PROD  = 4'b0010,
        M_ROUND = 4'b0100,
        M_PACK  = 4'b1000
    } mul_state_t;

    mul_state_t        state_reg, state_next;
    logic [1:0]        step_reg;
    logic [DATA_W-1:0] ma_reg, mb_reg;
    logic              neg_reg;
    sh_t               sh_reg;
    logic [127:0]      acc_reg;
    logic [DATA_W-1:0] res_reg;
    logic              ovf_reg;
    logic              done_reg;

    logic [31:0]       a_half, b_half;
    logic [63:0]       pp;
    logic [1:0]        pp_pos;
    logic [127:0]      pp_aligned;
    logic [127:0]      rounded;
    sat_t              packed_res;

    // partial product for the current step
    always_comb
    begin
        a_half = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        b_half = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp     = {32'd0, a_half} * {32'd0, b_half};
        pp_pos = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
        case (pp_pos)
            2'd0:    pp_aligned = {64'd0, pp};
            2'd1:    pp_aligned = {32'd0, pp, 32'd0};
            default: pp_aligned = {pp, 64'd0};
        endcase
    end

    // round to nearest, ties away from zero, then drop the fraction bits
    always_comb
    begin
        case (sh_reg)
            SH_15:   rounded = (acc_reg + (128'd1 << 14)) >> 15;
            SH_30:   rounded = (acc_reg + (128'd1 << 29)) >> 30;
            default: rounded = (acc_reg + (128'd1 << 23)) >> 24;
        endcase
        packed_res = sat_pack(neg_reg, acc_reg);
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE:  if (start) state_next = M_PROD;
            M_PROD:  if (step_reg == 2'd3) state_next = M_ROUND;
            M_ROUND: state_next = M_PACK;
            M_PACK:  state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            step_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == M_PACK);
            if (state_reg == M_PROD)
            begin
                step_reg <= step_reg + 2'd1;
            end
            else
            begin
                step_reg <= 2'd0;
            end
        end
    end

    // operand and accumulator datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == M_IDLE && start)
        begin
            ma_reg  <= mag64(a);
            mb_reg  <= mag64(b);
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
            sh_reg  <= sh;
            acc_reg <= 128'd0;
        end
        else if (state_reg == M_PROD)
        begin
            acc_reg <= acc_reg + pp_aligned;
        end
        else if (state_reg == M_ROUND)
        begin
            acc_reg <= rounded;
        end
        if (state_reg == M_PACK)
        begin
            res_reg <= packed_res.val;
            ovf_reg <= packed_res.ovf;
        end
    end

    assign res  = res_reg;
    assign ovf  = ovf_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- src/jpd_div.sv -----
// jpd_div: radix-2 restoring divider giving round(n * 2^24 / d), saturated.
// Depends on jpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jpd_div
    import jpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] num,
    input  wire logic [DATA_W-1:0] den,
    output logic      [DATA_W-1:0] res,
    output logic                   ovf,
    output logic                   done
);

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_ITER  = 4'b0010,
        D_ROUND = 4'b0100,
        D_PACK  = 4'b1000
    } div_state_t;

    localparam int CNT_W = $clog2(DVD_W);

    div_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  q_reg;
    logic [DVD_W:0]    qr_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] md_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] res_reg;
    logic              ovf_reg;
    logic              done_reg;

    logic [DATA_W-1:0] trial;
    logic              ge;
    logic              round_up;
    logic              den_zero;
    sat_t              packed_res;

    // one quotient bit per cycle; remainder stays below the divisor
    always_comb
    begin
        trial      = {rem_reg[DATA_W-2:0], dvd_reg[DVD_W-1]};
        ge         = (trial >= md_reg);
        round_up   = (rem_reg >= (md_reg - rem_reg));
        den_zero   = (den == 64'd0);
        packed_res = sat_pack(neg_reg, {{(128-DVD_W-1){1'b0}}, qr_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:  if (start && !den_zero) state_next = D_ITER;
            D_ITER:  if (cnt_reg == '0) state_next = D_ROUND;
            D_ROUND: state_next = D_PACK;
            D_PACK:  state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_PACK) || (state_reg == D_IDLE && start && den_zero);
            if (state_reg == D_IDLE)
            begin
                cnt_reg <= CNT_W'(DVD_W - 1);
            end
            else if (state_reg == D_ITER)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // quotient, remainder and result
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    dvd_reg <= {mag64(num), {DIV_SH{1'b0}}};
                    md_reg  <= mag64(den);
                    neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
                    rem_reg <= '0;
                    q_reg   <= '0;
                    // zero divisor: clamp by the sign of the numerator; a zero numerator gives zero
                    if (den_zero)
                    begin
                        ovf_reg <= 1'b1;
                        if (num == 64'd0)
                        begin
                            res_reg <= '0;
                        end
                        else if (num[DATA_W-1])
                        begin
                            res_reg <= LIM_NEG;
                        end
                        else
                        begin
                            res_reg <= LIM_POS;
                        end
                    end
                end
            end
            D_ITER:
            begin
                rem_reg <= ge ? (trial - md_reg) : trial;
                q_reg   <= {q_reg[DVD_W-2:0], ge};
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            end
            D_ROUND:
            begin
                qr_reg <= {1'b0, q_reg} + {{DVD_W{1'b0}}, round_up};
            end
            D_PACK:
            begin
                res_reg <= packed_res.val;
                ovf_reg <= packed_res.ovf;
            end
            default:
            begin
                qr_reg <= qr_reg;
            end
        endcase
    end

    assign res  = res_reg;
    assign ovf  = ovf_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- src/jpd_dp.sv -----
// jpd_dp: datapath with register file, saturating alu, multiplier, divider
// and the result registers. Depends on jpd_pkg, jpd_ram, jpd_mul, jpd_div.
`timescale 1ns / 1ps
`default_nettype none

module jpd_dp
    import jpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    input  wire logic [CFG_W-1:0]  point,
    input  wire logic [CFG_W-1:0]  alpha_q,
    input  wire logic [CFG_W-1:0]  beta_q,
    output logic      [DEG_W-1:0]  degree_index,
    output logic      [DATA_W-1:0] poly_value,
    output logic      [DATA_W-1:0] deriv_value,
    output logic                   last,
    output logic                   overflow
);

    logic [DATA_W-1:0] x_reg;
    logic              ovf_reg;
    logic              alu_done_reg;
    logic [DEG_W-1:0]  degree_reg;
    logic [DATA_W-1:0] poly_reg;
    logic [DATA_W-1:0] deriv_reg;
    logic              last_reg;
    logic              overflow_reg;

    logic [DATA_W-1:0] rd_a, rd_b;
    logic [DATA_W-1:0] opa, opb;
    logic [DATA_W-1:0] alpha_ext, beta_ext;
    logic [DATA_W:0]   sum65, diff65;
    sat_t              alu_res;
    logic              alu_fire;
    logic              mul_start, div_start;
    logic [DATA_W-1:0] mul_res, div_res;
    logic              mul_ovf, div_ovf, mul_done, div_done;
    logic              we;
    logic [DATA_W-1:0] wdata;

    function automatic sat_t sat65(input logic [DATA_W:0] r);
        sat_t s;
        s.val = r[DATA_W-1:0];
        s.ovf = 1'b0;
        if (r[DATA_W] != r[DATA_W-1])
        begin
            s.val = r[DATA_W] ? LIM_NEG : LIM_POS;
            s.ovf = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] pick(input logic [OPND_W-1:0] code,
                                               input logic [DATA_W-1:0] rd,
                                               input logic [DATA_W-1:0] x,
                                               input logic [DATA_W-1:0] al,
                                               input logic [DATA_W-1:0] be);
        if (!code[OPND_W-1])
        begin
            return rd;
        end
        case (code)
            K_ONE:   return ONE_Q24;
            K_TWO:   return TWO_Q24;
            K_X:     return x;
            K_ALPHA: return al;
            K_BETA:  return be;
            K_C40:   return ONE_Q40;
            default: return '0;
        endcase
    endfunction

    // working registers
    jpd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .clk     (clk),
        .we      (we),
        .waddr   (cmd.uop.dst),
        .wdata   (wdata),
        .raddr_a (cmd.uop.a[RF_AW-1:0]),
        .raddr_b (cmd.uop.b[RF_AW-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // operand selection and alu
    always_comb
    begin
        alpha_ext = {{(DATA_W-CFG_W){alpha_q[CFG_W-1]}}, alpha_q};
        beta_ext  = {{(DATA_W-CFG_W){beta_q[CFG_W-1]}}, beta_q};
        opa       = pick(cmd.uop.a, rd_a, x_reg, alpha_ext, beta_ext);
        opb       = pick(cmd.uop.b, rd_b, x_reg, alpha_ext, beta_ext);
        sum65     = {opa[DATA_W-1], opa} + {opb[DATA_W-1], opb};
        diff65    = {opa[DATA_W-1], opa} - {opb[DATA_W-1], opb};
        case (cmd.uop.op)
            OP_ADD:  alu_res = sat65(sum65);
            OP_SUB:  alu_res = sat65(diff65);
            OP_SHL:  alu_res = '{val: {opa[DATA_W-16:0], 15'd0}, ovf: 1'b0};
            default: alu_res = '{val: opa, ovf: 1'b0};
        endcase
        alu_fire  = cmd.start && ((cmd.uop.op == OP_ADD) || (cmd.uop.op == OP_SUB) ||
                                  (cmd.uop.op == OP_MOV) || (cmd.uop.op == OP_SHL));
        mul_start = cmd.start && (cmd.uop.op == OP_MUL);
        div_start = cmd.start && (cmd.uop.op == OP_DIV);
        we        = alu_fire || mul_done || div_done;
        if (mul_done)
        begin
            wdata = mul_res;
        end
        else if (div_done)
        begin
            wdata = div_res;
        end
        else
        begin
            wdata = alu_res.val;
        end
    end

    jpd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa),
        .b     (opb),
        .sh    (cmd.uop.sh),
        .res   (mul_res),
        .ovf   (mul_ovf),
        .done  (mul_done)
    );

    jpd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (opa),
        .den   (opb),
        .res   (div_res),
        .ovf   (div_ovf),
        .done  (div_done)
    );

    // sticky overflow per point and completion status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg      <= 1'b0;
            alu_done_reg <= 1'b0;
        end
        else
        begin
            alu_done_reg <= alu_fire;
            if (cmd.load_x)
            begin
                ovf_reg <= 1'b0;
            end
            else
            begin
                ovf_reg <= ovf_reg || (alu_fire && alu_res.ovf) || (mul_done && mul_ovf) ||
                           (div_done && div_ovf);
            end
        end
    end

    // evaluation point and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
        begin
            x_reg <= {{(DATA_W-CFG_W){point[CFG_W-1]}}, point};
        end
        if (cmd.start && cmd.uop.op == OP_EMIT)
        begin
            degree_reg   <= cmd.degree;
            poly_reg     <= opa;
            deriv_reg    <= opb;
            last_reg     <= cmd.last;
            overflow_reg <= ovf_reg;
        end
    end

    assign stat.done    = alu_done_reg || mul_done || div_done;
    assign degree_index = degree_reg;
    assign poly_value   = poly_reg;
    assign deriv_value  = deriv_reg;
    assign last         = last_reg;
    assign overflow     = overflow_reg;

endmodule

`default_nettype wire

// ----- src/jpd_ctrl.sv -----
// jpd_ctrl: controller fsm stepping through the microcode, one operation at a time.
// Depends on jpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jpd_ctrl
    import jpd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             point_valid,
    output logic                  point_ready,
    output logic                  result_valid,
    input  wire logic             result_ready,
    input  wire logic [DEG_W-1:0] max_degree,
    output dp_cmd_t               cmd,
    input  wire dp_stat_t         stat
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_EXEC  = 5'b00100,
        S_WAIT  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [DEG_W-1:0] deg_reg, deg_next;
    logic [DEG_W-1:0] deg_lim;
    uop_t             uop;
    logic             is_last;

    always_comb
    begin
        uop     = ucode(pc_reg);
        deg_lim = (max_degree > MAX_DEGREE_LIMIT) ? MAX_DEGREE_LIMIT : max_degree;
        is_last = (deg_reg == deg_lim);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        deg_next   = deg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    state_next = S_ISSUE;
                    pc_next    = '0;
                    deg_next   = '0;
                end
            end
            S_ISSUE:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = (uop.op == OP_EMIT) ? S_OUT : S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = S_ISSUE;
                    pc_next    = pc_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (result_ready)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                        deg_next   = deg_reg + 1'b1;
                        pc_next    = uop.br ? LOOP_PC : (pc_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            deg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            deg_reg   <= deg_next;
        end
    end

    // commands to the datapath
    always_comb
    begin
        cmd.load_x   = (state_reg == S_IDLE) && point_valid;
        cmd.start    = (state_reg == S_EXEC);
        cmd.uop      = uop;
        cmd.degree   = deg_reg;
        cmd.last     = is_last;
        point_ready  = (state_reg == S_IDLE);
        result_valid = (state_reg == S_OUT);
    end

endmodule

`default_nettype wire

// ----- src/jacobi_poly_with_derivative.sv -----
// jacobi_poly_with_derivative: top level, apb registers plus controller and datapath.
// Depends on jpd_pkg, jpd_ctrl, jpd_dp.
//
//   channel   handshake                    payload
//   point     point_valid / point_ready    point
//   result    result_valid / result_ready  degree_index, poly_value, deriv_value,
//                                          last, overflow
//   config    apb psel/penable/pwrite      paddr, pwdata, prdata
//
// Each point yields max_degree+1 result transactions, lowest degree first.
// Degrees 0 and 1 come from the microcode prologue; every further degree runs
// 14 products through one shared 64-bit multiplier and 2 quotients through a
// one-bit-per-cycle divider.
// A new point is taken only after the last result transaction of the previous one.
// A stalled result holds the sequencer; no work is lost. Reset needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_poly_with_derivative
    import jpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic      [CFG_W-1:0]  prdata,
    output logic                   pready,
    input  wire logic              point_valid,
    output logic                   point_ready,
    input  wire logic [CFG_W-1:0]  point,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic      [DEG_W-1:0]  degree_index,
    output logic      [DATA_W-1:0] poly_value,
    output logic      [DATA_W-1:0] deriv_value,
    output logic                   last,
    output logic                   overflow
);

    logic [CFG_W-1:0] alpha_q_reg;
    logic [CFG_W-1:0] beta_q_reg;
    logic [DEG_W-1:0] max_degree_reg;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    // configuration registers
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_q_reg    <= '0;
            beta_q_reg     <= '0;
            max_degree_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ALPHA:  alpha_q_reg    <= pwdata;
                REG_BETA:   beta_q_reg     <= pwdata;
                REG_DEGREE: max_degree_reg <= pwdata[DEG_W-1:0];
                default:    max_degree_reg <= max_degree_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_ALPHA:  prdata = alpha_q_reg;
            REG_BETA:   prdata = beta_q_reg;
            REG_DEGREE: prdata = {{(CFG_W-DEG_W){1'b0}}, max_degree_reg};
            default:    prdata = '0;
        endcase
    end

    jpd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .max_degree   (max_degree_reg),
        .cmd          (cmd),
        .stat         (stat)
    );

    jpd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .point        (point),
        .alpha_q      (alpha_q_reg),
        .beta_q       (beta_q_reg),
        .degree_index (degree_index),
        .poly_value   (poly_value),
        .deriv_value  (deriv_value),
        .last         (last),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire

// ----- src/jpd_checker.sv -----
// jpd_port_checker: port-level assertions for the jacobi evaluator, bound to the top level.
// Depends on jacobi_poly_with_derivative (bind target).
`timescale 1ns / 1ps
`default_nettype none

module jpd_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        point_valid,
    input wire logic        point_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic        last,
    input wire logic [63:0] poly_value
);

    // one point in flight: never ready for a point while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(point_ready && result_valid))
        else $error("point_ready and result_valid high together");

    // an accepted point keeps the block busy
    a_busy_after_point: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point_ready) |=> !point_ready)
        else $error("point_ready high right after a point transaction");

    // the last result ends the burst
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && last) |=> !result_valid)
        else $error("result offered right after the last transaction");

    // a non-final result does not release the input side
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !last) |=> !point_ready)
        else $error("point_ready high in the middle of a result burst");

    // stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(poly_value)))
        else $error("stalled result changed");

endmodule

bind jacobi_poly_with_derivative jpd_port_checker u_jpd_port_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .last         (last),
    .poly_value   (poly_value)
);

`default_nettype wire
